// ===== rtl/biquad_iir_lowpass_top_macros.svh =====
// assertion macros shared by the biquad filter rtl
// no dependencies; expects clk and rst in the including scope
`ifndef BIQUAD_IIR_LOWPASS_TOP_MACROS_SVH
`define BIQUAD_IIR_LOWPASS_TOP_MACROS_SVH

// same-cycle implication
`define BIQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("biquad same-cycle check failed");

// next-cycle implication
`define BIQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("biquad next-cycle check failed");

`endif

// ===== rtl/biq_pkg.sv =====
// types and constants for the biquad iir low-pass filter
// no dependencies; used by all rtl modules
package biq_pkg;

  localparam int COEF_FRAC = 20;
  localparam int HIST_FRAC = 16;
  localparam int FF_SHIFT  = COEF_FRAC - HIST_FRAC;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_B0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_B1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_A1   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_A2   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN = 3'd5;

  localparam int RST_B0   = 5812;
  localparam int RST_B1   = 11624;
  localparam int RST_B2   = 5812;
  localparam int RST_A1   = -1865031;
  localparam int RST_A2   = 839702;
  localparam int RST_GAIN = 1048576;

  localparam logic [1:0] WARM_DONE = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MB0,
    ST_MB1,
    ST_MB2,
    ST_DRAIN_FF,
    ST_F16,
    ST_MGL,
    ST_MGH,
    ST_MA1,
    ST_MA2,
    ST_DRAIN_FB,
    ST_FIN,
    ST_WB
  } state_t;

  typedef enum logic [2:0] {
    MUL_B0_X,
    MUL_B1_X1,
    MUL_B2_X2,
    MUL_G_LO,
    MUL_G_HI,
    MUL_A1_Y1,
    MUL_A2_Y2
  } mul_sel_t;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_ADD_HI,
    ACC_SUB
  } acc_op_t;

  typedef struct packed {
    logic     load_x;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     f16_en;
    logic     y_en;
    logic     wb;
    logic     warm;
  } dp_cmd_t;

endpackage

// ===== rtl/biq_datapath.sv =====
// biquad datapath: coefficient registers, history, shared multiplier and accumulator
// depends on biq_pkg; driven by biq_ctrl commands
module biq_datapath import biq_pkg::*; #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int COEF_WIDTH   = 24
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [CFG_IDX_W-1:0]           cfg_index,
  input  logic [COEF_WIDTH-1:0]          cfg_data,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
  input  dp_cmd_t                        cmd,
  output logic [SAMPLE_WIDTH-1:0]        sample_out
);

  localparam int SW  = SAMPLE_WIDTH;
  localparam int CW  = COEF_WIDTH;
  localparam int HW  = SW + HIST_FRAC;
  localparam int F   = CW + SW - 2;
  localparam int LO  = (F + 1) / 2;
  localparam int OPW = (HW > LO + 1) ? HW : LO + 1;
  localparam int PW  = CW + OPW;
  localparam int M1  = (CW + F > CW + HW) ? CW + F : CW + HW;
  localparam int M2  = (M1 > COEF_FRAC + HW) ? M1 : COEF_FRAC + HW;
  localparam int ACW = M2 + 1;

  logic signed [CW-1:0]  coef_b0, coef_b1, coef_b2, coef_a1, coef_a2, gain;
  logic signed [SW-1:0]  x, x1, x2;
  logic signed [HW-1:0]  y1, y2, y;
  logic signed [F-1:0]   f16;
  logic signed [PW-1:0]  prod;
  acc_op_t               acc_op_q;
  logic signed [ACW-1:0] acc;

  logic signed [CW-1:0]  mul_a;
  logic signed [OPW-1:0] mul_b;
  logic signed [ACW-1:0] prod_ext;
  logic signed [ACW-1:0] ff_rnd;
  logic signed [ACW-1:0] acc_rnd;
  logic signed [HW-1:0]  y_sat;
  logic signed [HW:0]    o_rnd;
  logic [SW-1:0]         o_sat;
  logic                  y_top_ok;

  // coefficient registers
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_b0 <= CW'(RST_B0);
      coef_b1 <= CW'(RST_B1);
      coef_b2 <= CW'(RST_B2);
      coef_a1 <= CW'(RST_A1);
      coef_a2 <= CW'(RST_A2);
      gain    <= CW'(RST_GAIN);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_B0:   coef_b0 <= cfg_data;
        REG_B1:   coef_b1 <= cfg_data;
        REG_B2:   coef_b2 <= cfg_data;
        REG_A1:   coef_a1 <= cfg_data;
        REG_A2:   coef_a2 <= cfg_data;
        REG_GAIN: gain    <= cfg_data;
        default: ;
      endcase
    end
  end

  // operand select
  always_comb begin
    case (cmd.mul_sel)
      MUL_B0_X: begin
        mul_a = coef_b0;
        mul_b = OPW'(x);
      end
      MUL_B1_X1: begin
        mul_a = coef_b1;
        mul_b = OPW'(x1);
      end
      MUL_B2_X2: begin
        mul_a = coef_b2;
        mul_b = OPW'(x2);
      end
      MUL_G_LO: begin
        mul_a = gain;
        mul_b = OPW'(f16[LO-1:0]);
      end
      MUL_G_HI: begin
        mul_a = gain;
        mul_b = OPW'($signed(f16[F-1:LO]));
      end
      MUL_A1_Y1: begin
        mul_a = coef_a1;
        mul_b = OPW'(y1);
      end
      MUL_A2_Y2: begin
        mul_a = coef_a2;
        mul_b = OPW'(y2);
      end
      default: begin
        mul_a = coef_b0;
        mul_b = OPW'(x);
      end
    endcase
  end

  assign prod_ext = {{(ACW-PW){prod[PW-1]}}, prod};

  // multiplier stage then accumulate stage
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (acc_op_q)
      ACC_LOAD:   acc <= prod_ext;
      ACC_ADD:    acc <= acc + prod_ext;
      ACC_ADD_HI: acc <= acc + (prod_ext <<< LO);
      ACC_SUB:    acc <= acc - prod_ext;
      default:    acc <= acc;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_op_q <= ACC_HOLD;
    end else begin
      acc_op_q <= cmd.acc_op;
    end
  end

  // rounding and saturation
  assign ff_rnd   = acc + (ACW'(1) << (FF_SHIFT - 1));
  assign acc_rnd  = acc + (ACW'(1) << (COEF_FRAC - 1));
  assign y_top_ok = (&acc_rnd[ACW-1:COEF_FRAC+HW-1]) | ~(|acc_rnd[ACW-1:COEF_FRAC+HW-1]);

  always_comb begin
    if (y_top_ok) begin
      y_sat = acc_rnd[COEF_FRAC+HW-1:COEF_FRAC];
    end else if (acc_rnd[ACW-1]) begin
      y_sat = {1'b1, {(HW-1){1'b0}}};
    end else begin
      y_sat = {1'b0, {(HW-1){1'b1}}};
    end
  end

  assign o_rnd = {y[HW-1], y} + ((HW+1)'(1) << (HIST_FRAC - 1));

  always_comb begin
    if (o_rnd[HW] == o_rnd[HW-1]) begin
      o_sat = o_rnd[HW-1:HIST_FRAC];
    end else if (o_rnd[HW]) begin
      o_sat = {1'b1, {(SW-1){1'b0}}};
    end else begin
      o_sat = {1'b0, {(SW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_x) begin
      x <= sample_in;
    end
    if (cmd.f16_en) begin
      f16 <= ff_rnd[F+FF_SHIFT-1:FF_SHIFT];
    end
    if (cmd.y_en) begin
      y <= y_sat;
    end
    if (cmd.wb) begin
      sample_out <= cmd.warm ? '0 : o_sat;
    end
  end

  // history, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      x1 <= '0;
      x2 <= '0;
      y1 <= '0;
      y2 <= '0;
    end else if (cmd.wb) begin
      x2 <= x1;
      x1 <= x;
      y2 <= y1;
      y1 <= cmd.warm ? '0 : y;
    end
  end

endmodule

// ===== rtl/biq_ctrl.sv =====
// biquad controller: sequences the shared multiplier and owns the handshakes
// depends on biq_pkg and the assertion macro header
`include "biquad_iir_lowpass_top_macros.svh"

module biq_ctrl import biq_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output dp_cmd_t cmd
);

  state_t     state, state_next;
  logic [1:0] warm_cnt;
  logic       wb_go;
  logic       in_acc;

  assign in_ready = (state == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign wb_go    = (state == ST_WB) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.mul_sel = MUL_B0_X;
    cmd.acc_op  = ACC_HOLD;
    cmd.warm    = (warm_cnt != WARM_DONE);
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_x = 1'b1;
          state_next = (warm_cnt == WARM_DONE) ? ST_MB0 : ST_WB;
        end
      end
      ST_MB0: begin
        cmd.mul_sel = MUL_B0_X;
        cmd.acc_op  = ACC_LOAD;
        state_next  = ST_MB1;
      end
      ST_MB1: begin
        cmd.mul_sel = MUL_B1_X1;
        cmd.acc_op  = ACC_ADD;
        state_next  = ST_MB2;
      end
      ST_MB2: begin
        cmd.mul_sel = MUL_B2_X2;
        cmd.acc_op  = ACC_ADD;
        state_next  = ST_DRAIN_FF;
      end
      ST_DRAIN_FF: begin
        state_next = ST_F16;
      end
      ST_F16: begin
        cmd.f16_en = 1'b1;
        state_next = ST_MGL;
      end
      ST_MGL: begin
        cmd.mul_sel = MUL_G_LO;
        cmd.acc_op  = ACC_LOAD;
        state_next  = ST_MGH;
      end
      ST_MGH: begin
        cmd.mul_sel = MUL_G_HI;
        cmd.acc_op  = ACC_ADD_HI;
        state_next  = ST_MA1;
      end
      ST_MA1: begin
        cmd.mul_sel = MUL_A1_Y1;
        cmd.acc_op  = ACC_SUB;
        state_next  = ST_MA2;
      end
      ST_MA2: begin
        cmd.mul_sel = MUL_A2_Y2;
        cmd.acc_op  = ACC_SUB;
        state_next  = ST_DRAIN_FB;
      end
      ST_DRAIN_FB: begin
        state_next = ST_FIN;
      end
      ST_FIN: begin
        cmd.y_en   = 1'b1;
        state_next = ST_WB;
      end
      ST_WB: begin
        if (!out_valid || out_ready) begin
          cmd.wb     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      warm_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (wb_go && (warm_cnt != WARM_DONE)) begin
        warm_cnt <= warm_cnt + 2'd1;
      end
      if (wb_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `BIQ_ASSERT_NOW(a_warm_bound, 1'b1, warm_cnt != 2'd3)
  `BIQ_ASSERT_NEXT(a_warm_path, in_acc && (warm_cnt != WARM_DONE), state == ST_WB)
  `BIQ_ASSERT_NEXT(a_full_path, in_acc && (warm_cnt == WARM_DONE), state == ST_MB0)
  `BIQ_ASSERT_NEXT(a_wb_valid, wb_go, out_valid && (state == ST_IDLE))

endmodule

// ===== rtl/biquad_iir_lowpass_top.sv =====
// top level of the biquad iir low-pass filter
// depends on biq_pkg, biq_ctrl and biq_datapath
//
// Direct-form-I second-order filter: one output sample per input sample.
// Each sample runs through one shared coefficient multiplier that issues
// seven products, one per cycle within a run of three and a run of four,
// plus drain and rounding steps, before its result is written to the output
// register; the next sample is accepted in the cycle after that write. The
// two warm-up samples after reset skip the products and give zero. A result
// waiting in the output register does not block acceptance of the next
// sample; that sample then holds in its last step until the output register
// is free, adding those cycles. The user must write coefficients through the
// cfg port only while the filter is idle; the block does not enforce this.
module biquad_iir_lowpass_top import biq_pkg::*; #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int COEF_WIDTH   = 24
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     s_axis_tdata,  // sample_in
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     m_axis_tdata,  // sample_out
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]                  cfg_index,
  input  logic [COEF_WIDTH-1:0]                 cfg_data
);

  localparam int TDW = ((SAMPLE_WIDTH + 7) / 8) * 8;

  dp_cmd_t                 cmd;
  logic [SAMPLE_WIDTH-1:0] sample_out;

  assign cfg_ready    = 1'b1;
  assign m_axis_tdata = TDW'(sample_out);

  biq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd)
  );

  biq_datapath #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COEF_WIDTH   (COEF_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .sample_in  ($signed(s_axis_tdata[SAMPLE_WIDTH-1:0])),
    .cmd        (cmd),
    .sample_out (sample_out)
  );

endmodule
